// File: design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: design/upd_pkg.sv
`timescale 1ns / 1ps

package upd_pkg;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_U       = 8'h75;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [2:0] SKIP_COUNT   = 3'd4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_in;
   } req_item_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       last_out;
      logic       bad_input;
   } rsp_item_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b0;
      h.value = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.ok    = 1'b1;
         h.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         h.ok    = 1'b1;
         h.value = c[3:0] + 4'd9;
      end
      return h;
   endfunction

endpackage

// File: design/upd_if.sv
`timescale 1ns / 1ps

interface upd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_in;

   modport source (output valid, output in_byte, output last_in, input ready);
   modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

interface upd_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] out_byte;
   logic       last_out;
   logic       bad_input;

   modport source (output valid, output byte_valid, output out_byte, output last_out,
                   output bad_input, input ready);
   modport sink   (input valid, input byte_valid, input out_byte, input last_out,
                   input bad_input, output ready);
endinterface

// File: design/upd_in_reg.sv
`timescale 1ns / 1ps

module upd_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   upd_req_if.sink               req_ch,
   output logic                  item_valid,
   output upd_pkg::req_item_type item,
   input  logic                  item_take
);
   import upd_pkg::*;

   logic         valid_ff;
   req_item_type item_ff;

   assign req_ch.ready = !valid_ff || item_take;
   assign item_valid   = valid_ff;
   assign item         = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         valid_ff <= 1'b1;
      end else if (item_take) begin
         valid_ff <= 1'b0;
      end
      if (req_ch.valid && req_ch.ready) begin
         item_ff.in_byte <= req_ch.in_byte;
         item_ff.last_in <= req_ch.last_in;
      end
   end

endmodule

// File: design/upd_decode.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upd_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  upd_pkg::req_item_type item,
   input  logic                  out_free,
   output logic                  item_take,
   output logic                  result_load,
   output upd_pkg::rsp_item_type result
);
   import upd_pkg::*;

   typedef enum logic [1:0] {
      MODE_COPY   = 2'd0,
      MODE_PCT    = 2'd1,
      MODE_SECOND = 2'd2,
      MODE_SKIP   = 2'd3
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [3:0] digit_ff, digit_in;
   logic [2:0] skip_ff, skip_in, skip_dec;
   logic       err_ff, err_in, err_upd;
   logic       have;
   logic [7:0] val;
   hex_type    hex;

   assign hex       = hex_decode(item.in_byte);
   assign item_take = item_valid && out_free;
   assign skip_dec  = (skip_ff != 3'd0) ? skip_ff - 3'd1 : skip_ff;

   always_comb begin
      mode_in  = mode_ff;
      digit_in = digit_ff;
      skip_in  = skip_ff;
      err_upd  = err_ff;
      have     = 1'b0;
      val      = 8'h00;
      if (!err_ff) begin
         unique case (mode_ff)
            MODE_COPY: begin
               if (item.in_byte == CHAR_PERCENT) begin
                  if (item.last_in) begin
                     err_upd = 1'b1;
                  end else begin
                     mode_in = MODE_PCT;
                  end
               end else begin
                  have = 1'b1;
                  val  = (item.in_byte == CHAR_PLUS) ? CHAR_SPACE : item.in_byte;
               end
            end
            MODE_PCT: begin
               if (item.in_byte == CHAR_U) begin
                  skip_in = SKIP_COUNT;
                  mode_in = MODE_SKIP;
               end else if (item.last_in || !hex.ok) begin
                  err_upd = 1'b1;
                  mode_in = MODE_COPY;
               end else begin
                  digit_in = hex.value;
                  mode_in  = MODE_SECOND;
               end
            end
            MODE_SECOND: begin
               have    = 1'b1;
               val     = hex.ok ? {digit_ff, hex.value} : {4'h0, digit_ff};
               mode_in = MODE_COPY;
            end
            MODE_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 3'd0) begin
                  mode_in = MODE_COPY;
               end
            end
         endcase
      end
      err_in = err_upd;
      // end of string: back to reset state
      if (item.last_in) begin
         mode_in  = MODE_COPY;
         digit_in = 4'h0;
         skip_in  = 3'd0;
         err_in   = 1'b0;
      end
   end

   assign result.byte_valid = have;
   assign result.out_byte   = val;
   assign result.last_out   = item.last_in;
   assign result.bad_input  = item.last_in && err_upd;
   assign result_load       = item_take && (have || item.last_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_COPY;
         digit_ff <= 4'h0;
         skip_ff  <= 3'd0;
         err_ff   <= 1'b0;
      end else if (item_take) begin
         mode_ff  <= mode_in;
         digit_ff <= digit_in;
         skip_ff  <= skip_in;
         err_ff   <= err_in;
      end
   end

   `ASSERT_IMPLIES(a_err_in_copy, clock, reset, err_ff, mode_ff == MODE_COPY)
   `ASSERT_IMPLIES(a_skip_range, clock, reset, mode_ff == MODE_SKIP,
                   skip_ff != 3'd0 && skip_ff <= SKIP_COUNT)
   `ASSERT_IMPLIES(a_skip_idle, clock, reset, mode_ff != MODE_SKIP, skip_ff == 3'd0)
   `ASSERT_NEXT(a_last_clears, clock, reset, item_take && item.last_in,
                mode_ff == MODE_COPY && !err_ff && skip_ff == 3'd0)

endmodule

// File: design/upd_out_reg.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upd_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  result_load,
   input  upd_pkg::rsp_item_type result,
   output logic                  out_free,
   upd_rsp_if.source             rsp_ch
);
   import upd_pkg::*;

   logic         valid_ff;
   rsp_item_type item_ff;

   assign out_free          = !valid_ff || rsp_ch.ready;
   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.byte_valid = item_ff.byte_valid;
   assign rsp_ch.out_byte   = item_ff.out_byte;
   assign rsp_ch.last_out   = item_ff.last_out;
   assign rsp_ch.bad_input  = item_ff.bad_input;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (result_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
      if (result_load) begin
         item_ff <= result;
      end
   end

   `ASSERT_IMPLIES(a_bad_at_end, clock, reset, valid_ff && item_ff.bad_input,
                   item_ff.last_out && !item_ff.byte_valid)
   `ASSERT_IMPLIES(a_beat_has_content, clock, reset, valid_ff,
                   item_ff.byte_valid || item_ff.last_out)
   `ASSERT_IMPLIES(a_load_when_free, clock, reset, result_load, out_free)

endmodule

// File: design/url_percent_decoder.sv
`timescale 1ns / 1ps

// URL percent decoder: one encoded byte per req beat, at most one rsp beat per byte, a byte
// every cycle unless the rsp side stalls; bytes pass an input, then a result register.
// The decode-state registers (mode, first digit, skip count, error) feed their own update.
// '+' gives a space, "%hh" one byte, "%u" drops itself and four more bytes. On a last byte
// a rsp beat is always given with last_out set; bad_input there means the string is to be
// discarded, and no decoded bytes follow an error within the string.
module url_percent_decoder (
   input  logic      clock,
   input  logic      reset,
   upd_req_if.sink   req_ch,
   upd_rsp_if.source rsp_ch
);
   import upd_pkg::*;

   logic         item_valid;
   req_item_type item;
   logic         item_take;
   logic         out_free;
   logic         result_load;
   rsp_item_type result;

   upd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   upd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .out_free    (out_free),
      .item_take   (item_take),
      .result_load (result_load),
      .result      (result)
   );

   upd_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .result_load (result_load),
      .result      (result),
      .out_free    (out_free),
      .rsp_ch      (rsp_ch)
   );

endmodule
